@@ src/s2da_pkg.sv @@
// Shared types and constants for the signed-to-decimal-ASCII converter.
`timescale 1ns / 1ps

package s2da_pkg;

    // Bits per BCD digit
    localparam int unsigned DIGIT_W = 4;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // BCD correction threshold and offset for the shift-add-3 step
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } s2da_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture a new value, clear BCD
        logic step;       // one shift-add-3 iteration
        logic shift;      // drop the top BCD digit
        logic sel_minus;  // output the minus sign
    } s2da_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic conv_done;   // last conversion iteration in progress
        logic lead_zero;   // top digit is zero and more digits follow
        logic neg;         // value is negative
        logic last_digit;  // top digit is the final one
    } s2da_status_t;

endpackage

@@ src/s2da_dp.sv @@
// Datapath: magnitude, binary-to-BCD conversion and character output.
`timescale 1ns / 1ps

module s2da_dp
    import s2da_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
) (
    input  logic                  aclk,
    input  logic [VALUE_BITS-1:0] value,
    input  s2da_cmd_t             cmd,
    output s2da_status_t          status,
    output logic [7:0]            text_char
);

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_W = $clog2(NUM_DIGITS + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIG_W-1:0]      dig_reg, dig_next;
    logic                  neg_reg, neg_next;
    logic [DIGIT_W-1:0]    top_digit;

    // Correct each BCD digit before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Select next register values
    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        dig_next = dig_reg;
        neg_next = neg_reg;
        priority if (cmd.load) begin
            neg_next = value[VALUE_BITS-1];
            mag_next = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_BITS);
            dig_next = DIG_W'(NUM_DIGITS);
        end else if (cmd.step) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end else if (cmd.shift) begin
            bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dig_next = dig_reg - DIG_W'(1);
        end else begin
            // Hold all registers
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        dig_reg <= dig_next;
        neg_reg <= neg_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // Report status to the controller
    assign status.conv_done  = (cnt_reg == CNT_W'(1));
    assign status.lead_zero  = (top_digit == '0) && (dig_reg > DIG_W'(1));
    assign status.neg        = neg_reg;
    assign status.last_digit = (dig_reg == DIG_W'(1));

    // Form the output character
    assign text_char = cmd.sel_minus ? CHAR_MINUS : (CHAR_ZERO | {4'd0, top_digit});

endmodule

@@ src/s2da_ctrl.sv @@
// Controller: sequences load, conversion, zero skipping and character beats.
`timescale 1ns / 1ps

module s2da_ctrl
    import s2da_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_last,
    input  s2da_status_t status,
    output s2da_cmd_t    cmd
);

    s2da_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        out_last      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (status.conv_done) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (status.lead_zero) begin
                    cmd.shift = 1'b1;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                out_valid     = 1'b1;
                cmd.sel_minus = 1'b1;
                if (out_ready) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                out_valid = 1'b1;
                out_last  = status.last_digit;
                if (out_ready) begin
                    cmd.shift = 1'b1;
                    if (status.last_digit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/signed_to_decimal_ascii.sv @@
// Top level: signed integer to decimal ASCII text stream.
`timescale 1ns / 1ps

// Accepts one two's-complement value per beat and returns its decimal text,
// one ASCII character per beat, most significant digit first, with '-' ahead
// of a negative value and tlast on the final character. The block handles
// one value at a time: it accepts the value, runs VALUE_BITS iterations of
// shift-add-3 binary-to-BCD conversion (one bit per cycle), drops each
// leading zero digit, decides whether a minus sign comes first, then sends
// the character beats, each held until the output side takes it.

module signed_to_decimal_ascii
    import s2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [VALUE_BITS-1:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_char
    output logic        m_tlast    // is_last
);

    // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    s2da_cmd_t    cmd;
    s2da_status_t status;

    s2da_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .status    (status),
        .cmd       (cmd)
    );

    s2da_dp #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .aclk      (aclk),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .text_char (m_tdata)
    );

endmodule
